// ===== rtl/core/bats_pkg.sv =====
// ----------------------------------------------------------------------------
// bats_pkg
// Shared types, phase codes and type-byte decoding for the auxiliary tag
// scanner.
// ----------------------------------------------------------------------------
package bats_pkg;

    localparam int POS_W   = 16;   // byte position wraps at 2**POS_W bytes
    localparam int SKIP_W  = 32;
    localparam int CNT_LOW_W = 24;
    localparam int ESIZE_W = 3;
    localparam int PHASE_W = 4;

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_TAG1    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_TAG2    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_TYPE    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_STRING  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SUBTYPE = 4'd5;
    localparam logic [PHASE_W-1:0] PH_COUNT0  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_COUNT1  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_COUNT2  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_COUNT3  = 4'd9;

    // Type characters
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_CU = 8'h43;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_IU = 8'h49;
    localparam logic [7:0] CH_SU = 8'h53;
    localparam logic [7:0] CH_Z = 8'h5A;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_I = 8'h69;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0]       tag_char_first;
        logic [7:0]       tag_char_second;
        logic [7:0]       type_code;
        logic [POS_W-1:0] type_offset;
    } t_out_word;

    // Fixed value size of a scalar type, zero when not a scalar.
    function automatic logic [3:0] scalar_size(input logic [7:0] t);
        logic [3:0] sz;
        sz = 4'd0;
        if (t inside {CH_A, CH_C, CH_CU})             sz = 4'd1;
        else if (t inside {CH_S, CH_SU})              sz = 4'd2;
        else if (t inside {CH_I, CH_IU, CH_F})        sz = 4'd4;
        else if (t == CH_D)                           sz = 4'd8;
        return sz;
    endfunction

    // Element size of an array subtype, zero when unknown.
    function automatic logic [ESIZE_W-1:0] element_size(input logic [7:0] t);
        logic [ESIZE_W-1:0] sz;
        sz = '0;
        if (t inside {CH_C, CH_CU})                   sz = 3'd1;
        else if (t inside {CH_S, CH_SU})              sz = 3'd2;
        else if (t inside {CH_I, CH_IU, CH_F})        sz = 3'd4;
        return sz;
    endfunction

endpackage

// ===== rtl/core/bats_in_stage.sv =====
// ----------------------------------------------------------------------------
// bats_in_stage
// Input register: holds one incoming word until the parser takes it.
// ----------------------------------------------------------------------------
module bats_in_stage
    import bats_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_word <= i_in_word;
        end
    end

endmodule

// ===== rtl/core/bats_parser.sv =====
// ----------------------------------------------------------------------------
// bats_parser
// Phase machine and counters: decodes one byte per step and flags a result
// when a known type byte arrives.
// ----------------------------------------------------------------------------
module bats_parser
    import bats_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    output logic      o_emit,
    output t_out_word o_result
);

    logic [PHASE_W-1:0]   r_phase,    n_phase;
    logic [7:0]           r_tag1,     n_tag1;
    logic [7:0]           r_tag2,     n_tag2;
    logic [POS_W-1:0]     r_pos,      n_pos;
    logic [SKIP_W-1:0]    r_skip,     n_skip;
    logic [ESIZE_W-1:0]   r_esize,    n_esize;
    logic [CNT_LOW_W-1:0] r_cnt,      n_cnt;

    logic [7:0]        b;
    logic [3:0]        sz;
    logic [ESIZE_W-1:0] esz;
    logic [SKIP_W-1:0] count;
    logic [SKIP_W-1:0] product;
    logic [SKIP_W-1:0] skip_dec;
    logic              is_str;

    assign b        = i_word.data_byte;
    assign sz       = scalar_size(b);
    assign esz      = element_size(b);
    assign is_str   = (b == CH_Z) || (b == CH_H);
    assign count    = {b, r_cnt};
    assign skip_dec = r_skip - SKIP_W'(1);

    // Element size is 1, 2 or 4: multiply by shifting, wrap at 32 bits.
    always_comb begin
        case (r_esize)
            3'd2:    product = {count[SKIP_W-2:0], 1'b0};
            3'd4:    product = {count[SKIP_W-3:0], 2'b00};
            default: product = count;
        endcase
    end

    assign o_emit = (r_phase == PH_TYPE) && ((sz != 4'd0) || is_str || (b == CH_B));
    assign o_result = '{tag_char_first:  r_tag1,
                        tag_char_second: r_tag2,
                        type_code:       b,
                        type_offset:     r_pos};

    always_comb begin
        n_phase = r_phase;
        n_tag1  = r_tag1;
        n_tag2  = r_tag2;
        n_skip  = r_skip;
        n_esize = r_esize;
        n_cnt   = r_cnt;
        n_pos   = r_pos + POS_W'(1);
        case (r_phase)
            PH_TAG1: begin
                n_tag1  = b;
                n_phase = PH_TAG2;
            end
            PH_TAG2: begin
                n_tag2  = b;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (sz != 4'd0) begin
                    n_skip  = {{(SKIP_W-4){1'b0}}, sz};
                    n_phase = PH_SKIP;
                end else if (is_str) begin
                    n_phase = PH_STRING;
                end else if (b == CH_B) begin
                    n_phase = PH_SUBTYPE;
                end else begin
                    n_phase = PH_TAG1;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = PH_TAG1;
                end
            end
            PH_STRING: begin
                if (b == CH_NUL) begin
                    n_phase = PH_TAG1;
                end
            end
            PH_SUBTYPE: begin
                n_esize = esz;
                if (esz != '0) begin
                    n_cnt   = '0;
                    n_phase = PH_COUNT0;
                end else begin
                    n_tag1  = b;
                    n_phase = PH_TAG2;
                end
            end
            PH_COUNT0: begin
                n_cnt   = {16'd0, b};
                n_phase = PH_COUNT1;
            end
            PH_COUNT1: begin
                n_cnt   = {r_cnt[23:16], b, r_cnt[7:0]};
                n_phase = PH_COUNT2;
            end
            PH_COUNT2: begin
                n_cnt   = {b, r_cnt[15:0]};
                n_phase = PH_COUNT3;
            end
            PH_COUNT3: begin
                n_skip  = product;
                n_phase = (product == '0) ? PH_TAG1 : PH_SKIP;
            end
            default: begin
                n_phase = PH_TAG1;
            end
        endcase
        // Drop any partial field at block end and restart from reset state.
        if (i_word.block_end) begin
            n_phase = PH_TAG1;
            n_tag1  = '0;
            n_tag2  = '0;
            n_pos   = '0;
            n_skip  = '0;
            n_esize = '0;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG1;
            r_tag1  <= '0;
            r_tag2  <= '0;
            r_pos   <= '0;
            r_skip  <= '0;
            r_esize <= '0;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tag1  <= n_tag1;
            r_tag2  <= n_tag2;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_esize <= n_esize;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/bats_out_stage.sv =====
// ----------------------------------------------------------------------------
// bats_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module bats_out_stage
    import bats_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_word,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== rtl/core/bam_aux_tag_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// bam_aux_tag_scanner_unit
// Byte-serial scanner for the auxiliary block of an alignment record: emits
// tag, type byte and type offset for every field with a known type.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_word  (byte, block end)
//  out     | output    | o_out_valid / i_out_ready | o_out_word (tags, type, offset)
//
//  One byte per cycle unless a result meets a full result register: each
//  accepted word is held in the input register until the phase machine
//  consumes it in a single step and, for a known type byte, writes the
//  result register. A stall on the output only holds the parser when the
//  byte at hand would produce a result; other bytes keep flowing. Synchronous
//  active-low reset clears the valid flags and all parser state.
//
module bam_aux_tag_scanner_unit
    import bats_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic      in_valid;
    t_in_word  in_word;
    logic      step;
    logic      emit;
    t_out_word result;
    logic      out_free;

    // Advance the parser whenever a byte is held, unless it would emit into
    // a full result register.
    assign step = in_valid && (!emit || out_free);

    bats_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_take     (step),
        .o_valid    (in_valid),
        .o_word     (in_word)
    );

    bats_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (in_word),
        .o_emit   (emit),
        .o_result (result)
    );

    bats_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && emit),
        .i_word      (result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== sim/bam_aux_tag_scanner_checker.sv =====
// ----------------------------------------------------------------------------
// bam_aux_tag_scanner_checker
// Watches both channels of the auxiliary tag scanner, predicts every tag
// record from the accepted input bytes and compares it with the output words.
// ----------------------------------------------------------------------------
module bam_aux_tag_scanner_checker
    import bats_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    logic [PHASE_W-1:0]   scan_phase;
    logic [7:0]           tag_first;
    logic [7:0]           tag_second;
    logic [POS_W-1:0]     byte_pos;
    logic [SKIP_W-1:0]    skip_left;
    logic [ESIZE_W-1:0]   elem_bytes;
    logic [CNT_LOW_W-1:0] count_low;
    t_out_word            tag_records_q[$];
    int                   fail_total = 0;

    function automatic int unsigned value_bytes(input logic [7:0] t);
        case (t)
            CH_A, CH_C, CH_CU: return 1;
            CH_S, CH_SU:       return 2;
            CH_I, CH_IU, CH_F: return 4;
            CH_D:              return 8;
            default:           return 0;
        endcase
    endfunction

    function automatic logic [ESIZE_W-1:0] array_elem_bytes(input logic [7:0] t);
        case (t)
            CH_C, CH_CU:       return 3'd1;
            CH_S, CH_SU:       return 3'd2;
            CH_I, CH_IU, CH_F: return 3'd4;
            default:           return 3'd0;
        endcase
    endfunction

    function void clear_scan();
        scan_phase = PH_TAG1;
        tag_first  = '0;
        tag_second = '0;
        byte_pos   = '0;
        skip_left  = '0;
        elem_bytes = '0;
        count_low  = '0;
    endfunction

    // Advance the parse by one byte; queue a record for every known type byte.
    function void scan_byte(input t_in_word w);
        logic [7:0]  b;
        t_out_word   rec;
        logic [31:0] count;
        int unsigned fixed;
        b = w.data_byte;
        case (scan_phase)
            PH_TAG1: begin
                tag_first  = b;
                scan_phase = PH_TAG2;
            end
            PH_TAG2: begin
                tag_second = b;
                scan_phase = PH_TYPE;
            end
            PH_TYPE: begin
                fixed = value_bytes(b);
                if (fixed != 0 || b == CH_Z || b == CH_H || b == CH_B) begin
                    rec.tag_char_first  = tag_first;
                    rec.tag_char_second = tag_second;
                    rec.type_code       = b;
                    rec.type_offset     = byte_pos;
                    tag_records_q.push_back(rec);
                end
                if (fixed != 0) begin
                    skip_left  = fixed;
                    scan_phase = PH_SKIP;
                end else if (b == CH_Z || b == CH_H) begin
                    scan_phase = PH_STRING;
                end else if (b == CH_B) begin
                    scan_phase = PH_SUBTYPE;
                end else begin
                    scan_phase = PH_TAG1;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0) scan_phase = PH_TAG1;
            end
            PH_STRING: begin
                if (b == CH_NUL) scan_phase = PH_TAG1;
            end
            PH_SUBTYPE: begin
                elem_bytes = array_elem_bytes(b);
                if (elem_bytes != 0) begin
                    count_low  = '0;
                    scan_phase = PH_COUNT0;
                end else begin
                    // rejected subtype starts the next tag
                    tag_first  = b;
                    scan_phase = PH_TAG2;
                end
            end
            PH_COUNT0: begin
                count_low  = {16'd0, b};
                scan_phase = PH_COUNT1;
            end
            PH_COUNT1: begin
                count_low[15:8] = b;
                scan_phase      = PH_COUNT2;
            end
            PH_COUNT2: begin
                count_low[23:16] = b;
                scan_phase       = PH_COUNT3;
            end
            default: begin
                count      = {b, count_low};
                skip_left  = SKIP_W'(elem_bytes) * count;
                scan_phase = (skip_left == 0) ? PH_TAG1 : PH_SKIP;
            end
        endcase
        if (w.block_end) clear_scan();
        else byte_pos = byte_pos + 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_out_word head;
        if (!i_rst_n) begin
            clear_scan();
            tag_records_q.delete();
        end else begin
            // results trail their bytes, so retire before predicting
            if (i_out_valid && i_out_ready) begin
                if (tag_records_q.size() == 0) begin
                    $error("unexpected result word 0x%0h", i_out_word);
                    fail_total++;
                end else begin
                    head = tag_records_q.pop_front();
                    check_field("tag_char_first", head.tag_char_first,
                                i_out_word.tag_char_first);
                    check_field("tag_char_second", head.tag_char_second,
                                i_out_word.tag_char_second);
                    check_field("type_code", head.type_code, i_out_word.type_code);
                    check_field("type_offset", head.type_offset, i_out_word.type_offset);
                end
            end
            if (i_in_valid && i_in_ready) scan_byte(i_in_word);
        end
        o_fail_count <= fail_total;
        o_pending    <= tag_records_q.size();
    end

endmodule

// ===== sim/bam_aux_tag_scanner_unit_tb.sv =====
// ----------------------------------------------------------------------------
// bam_aux_tag_scanner_unit_tb
// Drives auxiliary-block byte streams into the tag scanner: directed fields of
// every type and every block-end position, then random records, truncated
// fields and noise. A checker beside the block predicts and compares every
// tag record.
// ----------------------------------------------------------------------------
module bam_aux_tag_scanner_unit_tb;
    import bats_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int HOLD_CYCLES  = 300;      // long output back-pressure
    localparam int RANDOM_BYTES = 900;
    localparam int TAIL_CYCLES  = 8;        // settle time before the verdict

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} t_rx_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    int        scan_fail_count;
    int        scan_pending;

    // Known type tables; the width is the value length for scalars and the
    // element length for array subtypes.
    logic [7:0]  scalar_types   [9] = '{CH_A, CH_C, CH_CU, CH_S, CH_SU,
                                        CH_I, CH_IU, CH_F, CH_D};
    int unsigned scalar_widths  [9] = '{1, 1, 1, 2, 2, 4, 4, 4, 8};
    logic [7:0]  array_subtypes [7] = '{CH_C, CH_CU, CH_S, CH_SU, CH_I, CH_IU, CH_F};
    int unsigned array_widths   [7] = '{1, 1, 2, 2, 4, 4, 4};

    logic [7:0]  field_q[$];        // bytes of the field being sent
    int          burst_left = 0;
    int          max_gap    = 6;
    int unsigned bytes_sent = 0;
    t_rx_mode    rx_mode    = RX_OPEN;
    bit          hold_req   = 1'b0;
    int unsigned rx_tick    = 0;

    bam_aux_tag_scanner_unit DUT (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_in_word,
        .o_out_valid, .i_out_ready, .o_out_word
    );

    bam_aux_tag_scanner_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid,
        .i_in_ready   (o_in_ready),
        .i_in_word,
        .i_out_valid  (o_out_valid),
        .i_out_ready,
        .i_out_word   (o_out_word),
        .o_fail_count (scan_fail_count),
        .o_pending    (scan_pending)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Result sink. Every mode but the open one stalls in its own way; a hold request
    // drops ready for a long stretch so the scanner backs up into its input.
    initial begin
        forever begin
            @(posedge i_clk);
            rx_tick++;
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:    i_out_ready <= 1'b1;
                    RX_RANDOM:  i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: i_out_ready <= ((rx_tick % 7) < 4);
                    default:    i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one byte and hold it until the scanner takes it. Between bursts of
    // random length, drop valid for a random gap (or none at all).
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{data_byte: b, block_end: last};
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        bytes_sent++;
    endtask

    // Assemble one field: two random tag characters, the type byte and a value
    // that matches the type. A width of zero on an array marks a rejected
    // subtype; the subtype byte then acts as a first tag character, so follow
    // it with a second character and a one-byte field to stay in step.
    function void build_field(input logic [7:0] ty, input int unsigned width,
                              input logic [7:0] sub, input logic [31:0] count);
        logic [31:0] span;
        int unsigned text_len;
        field_q.delete();
        field_q.push_back(8'($urandom));
        field_q.push_back(8'($urandom));
        field_q.push_back(ty);
        if (ty == CH_Z || ty == CH_H) begin
            text_len = $urandom_range(0, 6);
            repeat (text_len) field_q.push_back(8'($urandom_range(1, 255)));
            field_q.push_back(CH_NUL);
        end else if (ty == CH_B) begin
            field_q.push_back(sub);
            if (width == 0) begin
                field_q.push_back(8'($urandom));
                field_q.push_back(CH_C);
                field_q.push_back(8'($urandom));
            end else begin
                for (int k = 0; k < 4; k++) field_q.push_back(count[8*k +: 8]);
                span = width * count;       // wraps at 32 bits like the block
                repeat (span) field_q.push_back(8'($urandom));
            end
        end else begin
            repeat (width) field_q.push_back(8'($urandom));
        end
    endfunction

    // Send the built field, or only its first keep bytes; close marks the
    // final byte sent as the block end.
    task automatic send_field(input bit close, input int unsigned keep);
        int unsigned n;
        n = (keep == 0) ? field_q.size() : keep;
        for (int unsigned k = 0; k < n; k++) send_byte(field_q[k], close && (k == n - 1));
    endtask

    function void random_field();
        int unsigned pick;
        int unsigned idx;
        logic [7:0]  ty;
        logic [31:0] count;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            idx = $urandom_range(0, 8);
            build_field(scalar_types[idx], scalar_widths[idx], 8'h00, 32'd0);
        end else if (pick < 60) begin
            build_field(pick[0] ? CH_Z : CH_H, 0, 8'h00, 32'd0);
        end else if (pick < 85) begin
            idx   = $urandom_range(0, 6);
            count = $urandom_range(0, 5);
            // now and then push the count high enough that the span wraps
            if ($urandom_range(0, 3) == 0) begin
                if (array_widths[idx] == 4) count[31:30] = 2'($urandom_range(0, 3));
                else if (array_widths[idx] == 2) count[31] = 1'($urandom_range(0, 1));
            end
            build_field(CH_B, array_widths[idx], array_subtypes[idx], count);
        end else if (pick < 93) begin
            do ty = 8'($urandom);
            while (ty inside {CH_C, CH_CU, CH_S, CH_SU, CH_I, CH_IU, CH_F});
            build_field(CH_B, 0, ty, 32'd0);
        end else begin
            do ty = 8'($urandom);
            while (ty inside {CH_A, CH_C, CH_CU, CH_S, CH_SU, CH_I, CH_IU, CH_F, CH_D,
                              CH_Z, CH_H, CH_B});
            build_field(ty, 0, 8'h00, 32'd0);
        end
    endfunction

    // Stop offering and wait until every predicted record has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (scan_pending != 0);
    endtask

    initial begin
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n;
        int unsigned idx;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: one block with every scalar, string and array type ----
        for (int k = 0; k < 9; k++) begin
            build_field(scalar_types[k], scalar_widths[k], 8'h00, 32'd0);
            if (k == 0) begin
                field_q[0] = 8'h00;
                field_q[1] = 8'hFF;
                field_q[3] = 8'hFF;
            end
            send_field(1'b0, 0);
        end
        build_field(CH_Z, 0, 8'h00, 32'd0);
        send_field(1'b0, 0);
        build_field(CH_H, 0, 8'h00, 32'd0);
        send_field(1'b0, 0);
        for (int k = 0; k < 7; k++) begin
            build_field(CH_B, array_widths[k], array_subtypes[k], 32'd1 + k[1:0]);
            send_field(k == 6, 0);
        end

        // unknown top-level type: no record, next byte restarts the tag
        build_field(8'hFF, 0, 8'h00, 32'd0);
        send_field(1'b0, 0);
        build_field(CH_A, 1, 8'h00, 32'd0);
        send_field(1'b1, 0);

        // rejected array subtype turns into the next first tag character
        build_field(CH_B, 0, 8'h00, 32'd0);
        send_field(1'b1, 0);

        // empty array, then counts whose span wraps to zero and to two bytes
        build_field(CH_B, 2, CH_S, 32'd0);
        send_field(1'b0, 0);
        build_field(CH_B, 4, CH_I, 32'h4000_0000);
        send_field(1'b0, 0);
        build_field(CH_B, 2, CH_SU, 32'h8000_0001);
        send_field(1'b1, 0);

        // block end on each part of a field; the parse restarts after the cut
        send_byte(8'($urandom), 1'b1);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
        build_field(CH_D, 8, 8'h00, 32'd0);
        send_field(1'b1, 3);
        build_field(CH_I, 4, 8'h00, 32'd0);
        send_field(1'b1, 5);
        build_field(CH_Z, 0, 8'h00, 32'd0);
        send_field(1'b1, field_q.size() - 1);
        build_field(CH_B, 4, CH_F, 32'd3);
        send_field(1'b1, 6);
        wait_drained();

        // ---- random: mostly well-formed records, mixed with cuts and noise ----
        for (int chunk = 0; chunk < 3; chunk++) begin
            rx_mode = t_rx_mode'(chunk + 1);
            if (chunk == 1) hold_req = 1'b1;    // sender keeps offering meanwhile
            stop_at = bytes_sent + RANDOM_BYTES / 3;
            while (bytes_sent < stop_at) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    n = $urandom_range(1, 4);
                    for (int unsigned k = 0; k < n; k++) begin
                        random_field();
                        send_field((k == n - 1) && ($urandom_range(0, 4) != 0), 0);
                    end
                end else if (pick < 80) begin
                    random_field();
                    send_field(1'b1, $urandom_range(1, field_q.size() - 1));
                end else if (pick < 88) begin
                    // array with a full 32-bit count, closed long before its end
                    idx = $urandom_range(0, 6);
                    build_field(CH_B, array_widths[idx], array_subtypes[idx], 32'd0);
                    for (int k = 4; k < 8; k++) field_q[k] = 8'($urandom);
                    repeat ($urandom_range(0, 3)) field_q.push_back(8'($urandom));
                    send_field(1'b1, 0);
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (scan_fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #12_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bats_pkg.sv
rtl/core/bats_in_stage.sv
rtl/core/bats_parser.sv
rtl/core/bats_out_stage.sv
rtl/core/bam_aux_tag_scanner_unit.sv
sim/bam_aux_tag_scanner_checker.sv
sim/bam_aux_tag_scanner_unit_tb.sv
